// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, suspended while reset is asserted.
`define CHK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define CHK_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/sdel_pkg.sv =====
`timescale 1ns / 1ps

package sdel_pkg;

  // Store and pattern sizing
  localparam int STORE_DEPTH = 1024;
  localparam int MAX_PATTERN = 8;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int PROG_W      = 4;
  localparam int PAT_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = 64;
  localparam int PLEN_W      = 4;
  localparam int IDX_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int ENTRY_W     = PROG_W + BYTE_W;

  // Commands carried by a transaction
  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREV_WAIT,
    ST_SEARCH,
    ST_READ_WAIT,
    ST_FINISH
  } state_t;

  // Request to the candidate compare unit
  typedef struct packed {
    logic [PROG_W-1:0] q;     // progress before the new byte
    logic [PROG_W-1:0] cand;  // candidate prefix length under test
    logic [BYTE_W-1:0] c;     // new byte
  } match_req_t;

endpackage

// ===== hdl/sdel_ram.sv =====
`timescale 1ns / 1ps

module sdel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== hdl/sdel_match.sv =====
`timescale 1ns / 1ps

// Tests one candidate prefix length: is pattern[0..cand-1] a suffix of
// pattern[0..q-1] followed by the new byte. A zero candidate always hits.
module sdel_match (
  input  logic [sdel_pkg::PAT_W-1:0] pattern_bytes,
  input  sdel_pkg::match_req_t       req,
  output logic                       hit
);

  logic [sdel_pkg::BYTE_W-1:0]    pat [sdel_pkg::MAX_PATTERN];
  logic [sdel_pkg::BYTE_W-1:0]    exp_b [sdel_pkg::MAX_PATTERN];
  logic [sdel_pkg::PROG_W:0]      src [sdel_pkg::MAX_PATTERN];

  // Unpack pattern bytes
  always_comb begin
    for (int j = 0; j < sdel_pkg::MAX_PATTERN; j++) begin
      pat[j] = pattern_bytes[sdel_pkg::BYTE_W*j +: sdel_pkg::BYTE_W];
    end
  end

  // Per-position compare, all lanes in parallel
  always_comb begin
    hit = 1'b1;
    for (int j = 0; j < sdel_pkg::MAX_PATTERN; j++) begin
      src[j] = {1'b0, req.q} + (sdel_pkg::PROG_W+1)'(j + 1) - {1'b0, req.cand};
      if (sdel_pkg::PROG_W'(j + 1) == req.cand) begin
        exp_b[j] = req.c;
      end else begin
        exp_b[j] = pat[src[j][sdel_pkg::PAT_IDX_W-1:0]];
      end
      if ((sdel_pkg::PROG_W'(j) < req.cand) && (pat[j] != exp_b[j])) begin
        hit = 1'b0;
      end
    end
  end

endmodule

// ===== hdl/substring_delete_all.sv =====
`timescale 1ns / 1ps

// Substring deleter: keeps appended text with every occurrence of the
// configured pattern removed, as if the leftmost match were deleted repeatedly.
// Input channel (in_valid / in_stall): one command per transaction: append a
// byte, read a kept byte by index, or clear the store. in_stall is high while
// a command is being worked on; one command is in flight at a time.
// Output channel (out_valid / out_stall): exactly one result per command,
// held in an output register; the block may take the next command while a
// result still waits there, but it cannot finish that command until the
// register is free, so a stalled receiver stalls the block after one command.
// Path from acceptance to out_valid: clear, unused commands, dropped appends,
// appends with pattern length 0 and out-of-range reads go straight to finish;
// in-range reads wait on the registered store read; appends read the previous
// match progress (when the store is not empty), then try candidate prefix
// lengths one at a time in the shared compare unit (up to pattern length + 1).
// Reset empties the store (count to zero, no clearing pass) and clears both
// configuration registers.
module substring_delete_all (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_cmd,
  input  logic [sdel_pkg::BYTE_W-1:0]    in_text_byte,
  input  logic [sdel_pkg::IDX_W-1:0]     in_read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [sdel_pkg::CNT_W-1:0]     out_kept_length,
  output logic [sdel_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                           out_overflow,
  output logic                           out_match_removed,
  input  logic                           cfg_we,
  input  logic [sdel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sdel_pkg::PAT_W-1:0]     cfg_wdata
);

  sdel_pkg::state_t state_r, state_nxt;
  logic [sdel_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [sdel_pkg::PROG_W-1:0] q_r, q_nxt;
  logic [sdel_pkg::PROG_W-1:0] cand_r, cand_nxt;
  logic [sdel_pkg::BYTE_W-1:0] byte_r, byte_nxt;
  logic [sdel_pkg::BYTE_W-1:0] rd_r, rd_nxt;
  logic                        ovf_r, ovf_nxt;
  logic                        rem_r, rem_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [sdel_pkg::CNT_W-1:0]  out_len_r, out_len_nxt;
  logic [sdel_pkg::BYTE_W-1:0] out_rd_r, out_rd_nxt;
  logic                        out_ovf_r, out_ovf_nxt;
  logic                        out_rem_r, out_rem_nxt;

  logic [sdel_pkg::PAT_W-1:0]  pat_bytes_r;
  logic [sdel_pkg::PLEN_W-1:0] pat_len_r;
  logic [sdel_pkg::PROG_W-1:0] len;
  logic [sdel_pkg::PROG_W-1:0] prev_q;
  logic [sdel_pkg::CNT_W-1:0]  pop;

  logic                          ram_we;
  logic [sdel_pkg::ADDR_W-1:0]   ram_addr;
  logic [sdel_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [sdel_pkg::ENTRY_W-1:0]  ram_rdata;

  sdel_pkg::match_req_t mreq;
  logic                 hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r <= '0;
      pat_len_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sdel_pkg::REG_PATTERN_BYTES:  pat_bytes_r <= cfg_wdata;
        sdel_pkg::REG_PATTERN_LENGTH: pat_len_r   <= cfg_wdata[sdel_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, saturated
  assign len = (pat_len_r > sdel_pkg::PLEN_W'(sdel_pkg::MAX_PATTERN)) ?
               sdel_pkg::PROG_W'(sdel_pkg::MAX_PATTERN) : pat_len_r;
  assign pop = sdel_pkg::CNT_W'(len - 1'b1);

  // Stored progress clamped below the pattern length
  assign prev_q = (ram_rdata[sdel_pkg::ENTRY_W-1 -: sdel_pkg::PROG_W] >= len) ?
                  (len - 1'b1) : ram_rdata[sdel_pkg::ENTRY_W-1 -: sdel_pkg::PROG_W];

  // Kept bytes with their match progress
  sdel_ram #(
    .WIDTH (sdel_pkg::ENTRY_W),
    .DEPTH (sdel_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Shared candidate compare unit
  assign mreq.q    = q_r;
  assign mreq.cand = cand_r;
  assign mreq.c    = byte_r;

  sdel_match u_match (
    .pattern_bytes (pat_bytes_r),
    .req           (mreq),
    .hit           (hit)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdel_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    q_r       <= q_nxt;
    cand_r    <= cand_nxt;
    byte_r    <= byte_nxt;
    rd_r      <= rd_nxt;
    ovf_r     <= ovf_nxt;
    rem_r     <= rem_nxt;
    out_len_r <= out_len_nxt;
    out_rd_r  <= out_rd_nxt;
    out_ovf_r <= out_ovf_nxt;
    out_rem_r <= out_rem_nxt;
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    q_nxt         = q_r;
    cand_nxt      = cand_r;
    byte_nxt      = byte_r;
    rd_nxt        = rd_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_len_nxt   = out_len_r;
    out_rd_nxt    = out_rd_r;
    out_ovf_nxt   = out_ovf_r;
    out_rem_nxt   = out_rem_r;
    ram_we        = 1'b0;
    ram_addr      = count_r[sdel_pkg::ADDR_W-1:0];
    ram_wdata     = {cand_r, byte_r};

    case (state_r)
      sdel_pkg::ST_IDLE: begin
        if (in_valid) begin
          byte_nxt  = in_text_byte;
          rd_nxt    = '0;
          ovf_nxt   = 1'b0;
          rem_nxt   = 1'b0;
          state_nxt = sdel_pkg::ST_FINISH;
          case (in_cmd)
            sdel_pkg::CMD_APPEND: begin
              if (count_r >= sdel_pkg::CNT_W'(sdel_pkg::STORE_DEPTH)) begin
                ovf_nxt = 1'b1;
              end else if (len == '0) begin
                // no pattern: push with zero progress
                ram_we    = 1'b1;
                ram_wdata = {{sdel_pkg::PROG_W{1'b0}}, in_text_byte};
                count_nxt = count_r + 1'b1;
              end else if (count_r == '0) begin
                q_nxt     = '0;
                cand_nxt  = sdel_pkg::PROG_W'(1);
                state_nxt = sdel_pkg::ST_SEARCH;
              end else begin
                // fetch progress of the top entry
                ram_addr  = sdel_pkg::ADDR_W'(count_r - 1'b1);
                state_nxt = sdel_pkg::ST_PREV_WAIT;
              end
            end
            sdel_pkg::CMD_READ: begin
              if (sdel_pkg::CNT_W'(in_read_index) < count_r) begin
                ram_addr  = sdel_pkg::ADDR_W'(in_read_index);
                state_nxt = sdel_pkg::ST_READ_WAIT;
              end
            end
            sdel_pkg::CMD_CLEAR: begin
              count_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      sdel_pkg::ST_PREV_WAIT: begin
        q_nxt     = prev_q;
        cand_nxt  = prev_q + 1'b1;
        state_nxt = sdel_pkg::ST_SEARCH;
      end

      // Longest candidate first; a zero candidate always hits
      sdel_pkg::ST_SEARCH: begin
        if (hit) begin
          state_nxt = sdel_pkg::ST_FINISH;
          if (cand_r == len) begin
            rem_nxt   = 1'b1;
            count_nxt = (count_r >= pop) ? (count_r - pop) : '0;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end else begin
          cand_nxt = cand_r - 1'b1;
        end
      end

      sdel_pkg::ST_READ_WAIT: begin
        rd_nxt    = ram_rdata[sdel_pkg::BYTE_W-1:0];
        state_nxt = sdel_pkg::ST_FINISH;
      end

      // Hand the result over once the output register is free
      sdel_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = count_r;
          out_rd_nxt    = rd_r;
          out_ovf_nxt   = ovf_r;
          out_rem_nxt   = rem_r;
          state_nxt     = sdel_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sdel_pkg::ST_IDLE;
      end
    endcase
  end

  // Ports
  assign in_stall          = (state_r != sdel_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_kept_length   = out_len_r;
  assign out_read_byte     = out_rd_r;
  assign out_overflow      = out_ovf_r;
  assign out_match_removed = out_rem_r;

endmodule

// ===== hdl/sdel_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sdel_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [sdel_pkg::CNT_W-1:0] out_kept_length,
  input logic                       out_overflow,
  input logic                       out_match_removed
);

  localparam logic [sdel_pkg::CNT_W-1:0] FULL_COUNT = sdel_pkg::CNT_W'(sdel_pkg::STORE_DEPTH);

  logic at_full;

  // Reported length equals a full store
  assign at_full = (out_kept_length == FULL_COUNT);

  // No result survives reset
  `CHK_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result stays offered
  `CHK_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")

  // One command in flight: busy right after acceptance
  `CHK_ASSERT(a_busy, in_valid && !in_stall |=> in_stall, "second command taken too early")

  // A dropped append only happens with a full store
  `CHK_ASSERT(a_ovf_full, out_valid && out_overflow |-> at_full && !out_match_removed, "bad drop")

  // Kept length never exceeds the store
  `CHK_ASSERT(a_len_bound, out_valid |-> out_kept_length <= FULL_COUNT, "kept length out of range")

endmodule

bind substring_delete_all sdel_checker u_sdel_checker (.*);
